@@ hdl/frdf_pkg.sv @@
// Shared constants, types and codes of the flood relay duplicate filter.
`timescale 1ns / 1ps
package frdf_pkg;

  localparam int RING_ENTRIES = 16;
  localparam int RING_IDX_W   = (RING_ENTRIES > 1) ? $clog2(RING_ENTRIES) : 1;
  localparam int KEY_W        = 64;

  localparam logic [RING_IDX_W-1:0] RING_LAST = RING_IDX_W'(RING_ENTRIES - 1);

  localparam logic [7:0] MIN_FRAME_LEN = 8'd16;
  localparam int         HOP_W         = 3;
  localparam logic [7:0] MARKER_RESET  = 8'hD1;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  localparam cfg_idx_t CFG_RELAY_ENABLE = 2'd0;
  localparam cfg_idx_t CFG_RELAY_MARKER = 2'd1;

  typedef logic [2:0] verdict_t;
  localparam verdict_t V_CRC      = 3'd0;
  localparam verdict_t V_SHORT    = 3'd1;
  localparam verdict_t V_RECEIVED = 3'd2;
  localparam verdict_t V_HOP      = 3'd3;
  localparam verdict_t V_DUP      = 3'd4;
  localparam verdict_t V_FWD      = 3'd5;

endpackage

@@ hdl/frdf_ifs.sv @@
// Handshake channel interfaces for input items, result items and configuration writes.
`timescale 1ns / 1ps
interface frdf_in_if;
  logic        valid;
  logic        ready;
  logic        crc_ok;
  logic [7:0]  frame_len;
  logic [31:0] src_addr;
  logic [31:0] packet_id;
  logic [7:0]  flags_in;
  logic [7:0]  relay_byte_in;

  modport source (output valid, crc_ok, frame_len, src_addr, packet_id, flags_in,
                  relay_byte_in, input ready);
  modport sink (input valid, crc_ok, frame_len, src_addr, packet_id, flags_in,
                relay_byte_in, output ready);
endinterface

interface frdf_out_if;
  import frdf_pkg::*;
  logic        valid;
  logic        ready;
  verdict_t    verdict;
  logic [7:0]  flags_out;
  logic [7:0]  relay_byte_out;
  logic [31:0] rx_total;
  logic [31:0] crc_errors;
  logic [31:0] forwarded_total;
  logic [31:0] duplicate_drops;
  logic [31:0] hop_drops;

  modport source (output valid, verdict, flags_out, relay_byte_out, rx_total, crc_errors,
                  forwarded_total, duplicate_drops, hop_drops, input ready);
  modport sink (input valid, verdict, flags_out, relay_byte_out, rx_total, crc_errors,
                forwarded_total, duplicate_drops, hop_drops, output ready);
endinterface

interface frdf_cfg_if;
  import frdf_pkg::*;
  logic                  valid;
  logic                  ready;
  cfg_idx_t              index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

@@ hdl/frdf_ram.sv @@
// Generic single-port-write, single-port-read RAM with a registered read.
`timescale 1ns / 1ps
module frdf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                        clk,
  input  logic                                        we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                            wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                            rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hdl/flood_relay_dedup_filter.sv @@
// Top level of the flood relay duplicate filter: verdict sequencer, seen ring and counters.
//
//   channel  | dir | handshake    | contents
//   in_ch    | in  | valid/ready  | crc_ok, frame_len, src_addr, packet_id, flags, relay byte
//   out_ch   | out | valid/ready  | verdict, flags_out, relay_byte_out, five counters
//   cfg_ch   | in  | valid/ready  | register index, write data
//
// An item that needs a ring search reads every entry of the seen ring RAM, one entry per
// cycle, before its result; other items go straight from acceptance to the result stage.
// The ring is cleared at reset through per-entry valid bits, so no clearing pass is needed.
// A result waiting on out_ch does not block acceptance of the next item but holds its result,
// and further input, until the output register is free. Configuration writes are always taken.
`timescale 1ns / 1ps
module flood_relay_dedup_filter (
  input  logic          clk,
  input  logic          rst_n,
  frdf_in_if.sink       in_ch,
  frdf_out_if.source    out_ch,
  frdf_cfg_if.sink      cfg_ch
);
  import frdf_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_FIN  = 2'd2;

  logic [1:0]            state_r, state_nxt;
  logic                  relay_en_r, relay_en_nxt;
  logic [7:0]            marker_r, marker_nxt;

  logic [31:0]           src_r, src_nxt;
  logic [31:0]           pid_r, pid_nxt;
  logic [7:0]            flags_r, flags_nxt;
  logic [7:0]            relay_in_r, relay_in_nxt;
  verdict_t              verdict_r, verdict_nxt;

  logic [RING_IDX_W-1:0] scan_idx_r, scan_idx_nxt;
  logic                  issue_r, issue_nxt;
  logic                  cmp_vld_r, cmp_vld_nxt;
  logic [RING_IDX_W-1:0] cmp_idx_r, cmp_idx_nxt;
  logic                  hit_r, hit_nxt;
  logic                  cur_hit;

  logic [RING_IDX_W-1:0]   head_r, head_nxt;
  logic [RING_ENTRIES-1:0] entry_vld_r, entry_vld_nxt;

  logic [31:0] rx_cnt_r, rx_cnt_nxt;
  logic [31:0] crc_cnt_r, crc_cnt_nxt;
  logic [31:0] fwd_cnt_r, fwd_cnt_nxt;
  logic [31:0] dup_cnt_r, dup_cnt_nxt;
  logic [31:0] hop_cnt_r, hop_cnt_nxt;

  logic        out_valid_r, out_valid_nxt;
  verdict_t    out_verdict_r, out_verdict_nxt;
  logic [7:0]  out_flags_r, out_flags_nxt;
  logic [7:0]  out_relay_r, out_relay_nxt;

  logic             in_acc;
  logic             load;
  logic             ram_we;
  logic [KEY_W-1:0] ram_rdata;
  logic [KEY_W-1:0] key;

  frdf_ram #(
    .WIDTH (KEY_W),
    .DEPTH (RING_ENTRIES)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (head_r),
    .wdata (key),
    .raddr (scan_idx_r),
    .rdata (ram_rdata)
  );

  assign key          = {src_r, pid_r};
  assign in_ch.ready  = (state_r == S_IDLE);
  assign cfg_ch.ready = 1'b1;
  assign in_acc       = in_ch.valid && in_ch.ready;
  assign load         = (state_r == S_FIN) && (!out_valid_r || out_ch.ready);
  assign ram_we       = load && (verdict_r == V_FWD);
  assign cur_hit      = entry_vld_r[cmp_idx_r] ? (ram_rdata == key) : (key == '0);

  assign out_ch.valid           = out_valid_r;
  assign out_ch.verdict         = out_verdict_r;
  assign out_ch.flags_out       = out_flags_r;
  assign out_ch.relay_byte_out  = out_relay_r;
  assign out_ch.rx_total        = rx_cnt_r;
  assign out_ch.crc_errors      = crc_cnt_r;
  assign out_ch.forwarded_total = fwd_cnt_r;
  assign out_ch.duplicate_drops = dup_cnt_r;
  assign out_ch.hop_drops       = hop_cnt_r;

  always_comb begin
    state_nxt       = state_r;
    relay_en_nxt    = relay_en_r;
    marker_nxt      = marker_r;
    src_nxt         = src_r;
    pid_nxt         = pid_r;
    flags_nxt       = flags_r;
    relay_in_nxt    = relay_in_r;
    verdict_nxt     = verdict_r;
    scan_idx_nxt    = scan_idx_r;
    issue_nxt       = issue_r;
    cmp_vld_nxt     = 1'b0;
    cmp_idx_nxt     = scan_idx_r;
    hit_nxt         = hit_r;
    head_nxt        = head_r;
    entry_vld_nxt   = entry_vld_r;
    rx_cnt_nxt      = rx_cnt_r;
    crc_cnt_nxt     = crc_cnt_r;
    fwd_cnt_nxt     = fwd_cnt_r;
    dup_cnt_nxt     = dup_cnt_r;
    hop_cnt_nxt     = hop_cnt_r;
    out_valid_nxt   = out_valid_r && !out_ch.ready;
    out_verdict_nxt = out_verdict_r;
    out_flags_nxt   = out_flags_r;
    out_relay_nxt   = out_relay_r;

    if (cfg_ch.valid) begin
      case (cfg_ch.index)
        CFG_RELAY_ENABLE: relay_en_nxt = cfg_ch.data[0];
        CFG_RELAY_MARKER: marker_nxt = cfg_ch.data;
        default: ;
      endcase
    end

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          src_nxt      = in_ch.src_addr;
          pid_nxt      = in_ch.packet_id;
          flags_nxt    = in_ch.flags_in;
          relay_in_nxt = in_ch.relay_byte_in;
          scan_idx_nxt = '0;
          issue_nxt    = 1'b1;
          hit_nxt      = 1'b0;
          state_nxt    = S_FIN;
          if (!in_ch.crc_ok) begin
            verdict_nxt = V_CRC;
          end else if (in_ch.frame_len < MIN_FRAME_LEN) begin
            verdict_nxt = V_SHORT;
          end else if (!relay_en_r) begin
            verdict_nxt = V_RECEIVED;
          end else if (in_ch.flags_in[HOP_W-1:0] == '0) begin
            verdict_nxt = V_HOP;
          end else begin
            verdict_nxt = V_FWD;
            state_nxt   = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (issue_r) begin
          cmp_vld_nxt = 1'b1;
          cmp_idx_nxt = scan_idx_r;
          if (scan_idx_r == RING_LAST) begin
            issue_nxt = 1'b0;
          end else begin
            scan_idx_nxt = scan_idx_r + 1'b1;
          end
        end
        if (cmp_vld_r) begin
          hit_nxt = hit_r || cur_hit;
          if (cmp_idx_r == RING_LAST) begin
            verdict_nxt = (hit_r || cur_hit) ? V_DUP : V_FWD;
            state_nxt   = S_FIN;
          end
        end
      end
      S_FIN: begin
        if (load) begin
          out_valid_nxt   = 1'b1;
          out_verdict_nxt = verdict_r;
          out_flags_nxt   = flags_r;
          out_relay_nxt   = relay_in_r;
          case (verdict_r)
            V_CRC: crc_cnt_nxt = crc_cnt_r + 32'd1;
            V_RECEIVED: rx_cnt_nxt = rx_cnt_r + 32'd1;
            V_HOP: begin
              rx_cnt_nxt  = rx_cnt_r + 32'd1;
              hop_cnt_nxt = hop_cnt_r + 32'd1;
            end
            V_DUP: begin
              rx_cnt_nxt  = rx_cnt_r + 32'd1;
              dup_cnt_nxt = dup_cnt_r + 32'd1;
            end
            V_FWD: begin
              rx_cnt_nxt    = rx_cnt_r + 32'd1;
              fwd_cnt_nxt   = fwd_cnt_r + 32'd1;
              out_flags_nxt = {flags_r[7:HOP_W], flags_r[HOP_W-1:0] - 1'b1};
              out_relay_nxt = marker_r;
              entry_vld_nxt[head_r] = 1'b1;
              head_nxt = (head_r == RING_LAST) ? '0 : head_r + 1'b1;
            end
            default: ;
          endcase
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      relay_en_r  <= 1'b0;
      marker_r    <= MARKER_RESET;
      issue_r     <= 1'b0;
      cmp_vld_r   <= 1'b0;
      hit_r       <= 1'b0;
      head_r      <= '0;
      entry_vld_r <= '0;
      rx_cnt_r    <= '0;
      crc_cnt_r   <= '0;
      fwd_cnt_r   <= '0;
      dup_cnt_r   <= '0;
      hop_cnt_r   <= '0;
      out_valid_r <= 1'b0;
      verdict_r   <= V_CRC;
      scan_idx_r  <= '0;
      cmp_idx_r   <= '0;
    end else begin
      state_r     <= state_nxt;
      relay_en_r  <= relay_en_nxt;
      marker_r    <= marker_nxt;
      issue_r     <= issue_nxt;
      cmp_vld_r   <= cmp_vld_nxt;
      hit_r       <= hit_nxt;
      head_r      <= head_nxt;
      entry_vld_r <= entry_vld_nxt;
      rx_cnt_r    <= rx_cnt_nxt;
      crc_cnt_r   <= crc_cnt_nxt;
      fwd_cnt_r   <= fwd_cnt_nxt;
      dup_cnt_r   <= dup_cnt_nxt;
      hop_cnt_r   <= hop_cnt_nxt;
      out_valid_r <= out_valid_nxt;
      verdict_r   <= verdict_nxt;
      scan_idx_r  <= scan_idx_nxt;
      cmp_idx_r   <= cmp_idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    src_r         <= src_nxt;
    pid_r         <= pid_nxt;
    flags_r       <= flags_nxt;
    relay_in_r    <= relay_in_nxt;
    out_verdict_r <= out_verdict_nxt;
    out_flags_r   <= out_flags_nxt;
    out_relay_r   <= out_relay_nxt;
  end

  a_head_advances: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |=> head_r == (($past(head_r) == RING_LAST) ? '0 : $past(head_r) + 1'b1))
    else $error("Ring head did not advance after an insert.");

  a_fwd_count: assert property (@(posedge clk) disable iff (!rst_n)
    (load && verdict_r == V_FWD) |=> fwd_cnt_r == $past(fwd_cnt_r) + 32'd1)
    else $error("Forwarded counter did not advance with a forwarded item.");

  a_scan_order: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN && cmp_vld_r && issue_r) |-> scan_idx_r == cmp_idx_r + 1'b1)
    else $error("Ring read and compare indexes fell out of step.");

  a_verdict_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_verdict_r <= V_FWD)
    else $error("Result carries an undefined verdict code.");

endmodule

@@ bench/testbench.sv @@
// Self-checking testbench for the flood relay duplicate filter, built around a scoreboard class.
`timescale 1ns / 1ps
module testbench;
  import frdf_pkg::*;

  typedef struct packed {
    logic        crc_ok;
    logic [7:0]  frame_len;
    logic [31:0] src_addr;
    logic [31:0] packet_id;
    logic [7:0]  flags;
    logic [7:0]  relay_byte;
  } frame_t;

  typedef struct packed {
    verdict_t    verdict;
    logic [7:0]  flags;
    logic [7:0]  relay_byte;
    logic [31:0] rx_total;
    logic [31:0] crc_errors;
    logic [31:0] forwarded_total;
    logic [31:0] duplicate_drops;
    logic [31:0] hop_drops;
  } report_t;

  localparam cfg_idx_t   CFG_SPARE_A = 2'd2;
  localparam cfg_idx_t   CFG_SPARE_B = 2'd3;
  localparam logic [7:0] HOP_MASK    = 8'h07;

  class relay_scoreboard;
    bit          relay_on;
    logic [7:0]  marker;
    logic [31:0] seen_src [RING_ENTRIES];
    logic [31:0] seen_pid [RING_ENTRIES];
    int unsigned head;
    logic [31:0] n_rx, n_crc, n_fwd, n_dup, n_hop;
    report_t     pending_reports[$];
    int unsigned errors;

    function new();
      relay_on = 1'b0;
      marker = MARKER_RESET;
      foreach (seen_src[i]) begin
        seen_src[i] = '0;
        seen_pid[i] = '0;
      end
      head = 0;
      n_rx = '0;
      n_crc = '0;
      n_fwd = '0;
      n_dup = '0;
      n_hop = '0;
      errors = 0;
    endfunction

    function void flag(string msg);
      errors++;
      if (errors <= 10) $display("mismatch at %0t: %s", $realtime, msg);
    endfunction

    function string show(report_t r);
      return $sformatf("verdict %0d flags %02h relay %02h rx %0d crc %0d fwd %0d dup %0d hop %0d",
                       r.verdict, r.flags, r.relay_byte, r.rx_total, r.crc_errors,
                       r.forwarded_total, r.duplicate_drops, r.hop_drops);
    endfunction

    function void write_reg(cfg_idx_t idx, logic [7:0] value);
      case (idx)
        CFG_RELAY_ENABLE: relay_on = value[0];
        CFG_RELAY_MARKER: marker = value;
        default: ;
      endcase
    endfunction

    function bit already_seen(logic [31:0] src, logic [31:0] pid);
      foreach (seen_src[i]) begin
        if (seen_src[i] == src && seen_pid[i] == pid) return 1'b1;
      end
      return 1'b0;
    endfunction

    function void note_frame(frame_t f);
      report_t    r;
      logic [2:0] hop;
      hop = f.flags[2:0];
      r.verdict = V_FWD;
      r.flags = f.flags;
      r.relay_byte = f.relay_byte;
      if (!f.crc_ok) begin
        n_crc = n_crc + 1;
        r.verdict = V_CRC;
      end else if (f.frame_len < MIN_FRAME_LEN) begin
        r.verdict = V_SHORT;
      end else begin
        n_rx = n_rx + 1;
        if (!relay_on) begin
          r.verdict = V_RECEIVED;
        end else if (hop == 3'd0) begin
          n_hop = n_hop + 1;
          r.verdict = V_HOP;
        end else if (already_seen(f.src_addr, f.packet_id)) begin
          n_dup = n_dup + 1;
          r.verdict = V_DUP;
        end else begin
          seen_src[head] = f.src_addr;
          seen_pid[head] = f.packet_id;
          head = (head + 1) % RING_ENTRIES;
          r.flags = (f.flags & ~HOP_MASK) | {5'b0, hop - 3'd1};
          r.relay_byte = marker;
          n_fwd = n_fwd + 1;
        end
      end
      r.rx_total = n_rx;
      r.crc_errors = n_crc;
      r.forwarded_total = n_fwd;
      r.duplicate_drops = n_dup;
      r.hop_drops = n_hop;
      pending_reports.push_back(r);
    endfunction

    function void check_result(report_t got);
      report_t want;
      if (pending_reports.size() == 0) begin
        flag({"result with nothing pending: ", show(got)});
        return;
      end
      want = pending_reports.pop_front();
      if (got.verdict !== want.verdict || got.flags !== want.flags ||
          got.relay_byte !== want.relay_byte || got.rx_total !== want.rx_total ||
          got.crc_errors !== want.crc_errors || got.forwarded_total !== want.forwarded_total ||
          got.duplicate_drops !== want.duplicate_drops || got.hop_drops !== want.hop_drops)
        flag({"expected ", show(want), ", got ", show(got)});
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;

  frdf_in_if  in_ch ();
  frdf_out_if out_ch ();
  frdf_cfg_if cfg_ch ();

  flood_relay_dedup_filter uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  relay_scoreboard sb = new();
  int unsigned     send_gap_pct = 0;
  int unsigned     recv_stall_pct = 0;
  int unsigned     hold_cycles = 0;
  bit              hold_started = 1'b0;
  int unsigned     stall_left = 0;
  logic [63:0]     recent_pairs[$];

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n === 1'b1) begin
      if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
        sb.check_result({out_ch.verdict, out_ch.flags_out, out_ch.relay_byte_out,
                         out_ch.rx_total, out_ch.crc_errors, out_ch.forwarded_total,
                         out_ch.duplicate_drops, out_ch.hop_drops});
      if (in_ch.valid === 1'b1 && in_ch.ready === 1'b1)
        sb.note_frame({in_ch.crc_ok, in_ch.frame_len, in_ch.src_addr, in_ch.packet_id,
                       in_ch.flags_in, in_ch.relay_byte_in});
      if (cfg_ch.valid === 1'b1 && cfg_ch.ready === 1'b1)
        sb.write_reg(cfg_ch.index, cfg_ch.data);
    end
  end

  always @(posedge clk) begin
    if (!hold_started && hold_cycles != 0) begin
      hold_started = 1'b1;
      stall_left = hold_cycles;
    end
    if (stall_left != 0) begin
      out_ch.ready <= 1'b0;
      stall_left--;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  initial begin
    #2_000_000;
    $display("FAILURE");
    $finish;
  end

  function automatic frame_t make_frame(logic crc_ok, logic [7:0] len, logic [31:0] src,
                                        logic [31:0] pid, logic [7:0] flags,
                                        logic [7:0] relay_byte);
    return {crc_ok, len, src, pid, flags, relay_byte};
  endfunction

  function automatic frame_t random_frame();
    frame_t      f;
    logic [63:0] pair;
    int unsigned pick;
    f.crc_ok = ($urandom_range(9) != 0);
    pick = $urandom_range(9);
    if (pick == 0) f.frame_len = 8'($urandom_range(15));
    else if (pick == 1) f.frame_len = 8'($urandom);
    else f.frame_len = 8'($urandom_range(255, 16));
    f.flags = 8'($urandom);
    f.relay_byte = 8'($urandom);
    pick = $urandom_range(9);
    if (recent_pairs.size() != 0 && pick < 4) begin
      pair = recent_pairs[$urandom_range(recent_pairs.size() - 1)];
      if (pick == 0) pair[$urandom_range(63)] ^= 1'b1;
    end else if (pick < 6) begin
      pair = {32'($urandom_range(7)), 32'($urandom)};
    end else begin
      pair = {32'($urandom), 32'($urandom)};
    end
    f.src_addr = pair[63:32];
    f.packet_id = pair[31:0];
    recent_pairs.push_back(pair);
    if (recent_pairs.size() > 24) void'(recent_pairs.pop_front());
    return f;
  endfunction

  task automatic send_frame(frame_t f);
    while ($urandom_range(99) < send_gap_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    {in_ch.crc_ok, in_ch.frame_len, in_ch.src_addr, in_ch.packet_id, in_ch.flags_in,
     in_ch.relay_byte_in} <= f;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
  endtask

  task automatic send_random(int unsigned count);
    repeat (count) send_frame(random_frame());
  endtask

  task automatic settle();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (sb.pending_reports.size() != 0);
  endtask

  task automatic set_register(cfg_idx_t idx, logic [7:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= value;
    do @(posedge clk); while (cfg_ch.ready !== 1'b1);
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    rst_n <= 1'b0;
    in_ch.valid <= 1'b0;
    {in_ch.crc_ok, in_ch.frame_len, in_ch.src_addr, in_ch.packet_id, in_ch.flags_in,
     in_ch.relay_byte_in} <= '0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.index <= CFG_RELAY_ENABLE;
    cfg_ch.data <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Relaying is off after reset, so good frames are only received.
    send_frame(make_frame(1'b0, 8'hFF, '1, '1, 8'hFF, 8'hFF));
    send_frame(make_frame(1'b1, 8'd15, 32'h1, 32'h2, 8'h07, 8'h00));
    send_frame(make_frame(1'b1, 8'd0, 32'h0, 32'h0, 8'h00, 8'h55));
    send_frame(make_frame(1'b1, 8'd16, 32'h3, 32'h4, 8'h01, 8'hAA));
    settle();
    set_register(CFG_RELAY_ENABLE, 8'h01);
    set_register(CFG_RELAY_MARKER, 8'h00);
    send_frame(make_frame(1'b1, 8'd40, 32'h5, 32'h6, 8'hF8, 8'h12));
    // The cleared ring makes the all-zero pair look seen.
    send_frame(make_frame(1'b1, 8'd16, 32'h0, 32'h0, 8'h01, 8'h34));
    send_frame(make_frame(1'b1, 8'hFF, '1, '1, 8'hFF, 8'hFF));
    send_frame(make_frame(1'b1, 8'hFF, '1, '1, 8'hFF, 8'h00));
    // Fill the rest of the ring so every cleared slot is overwritten.
    for (int i = 1; i < 16; i++)
      send_frame(make_frame(1'b1, 8'(16 + i), 32'(i), 32'h8000_0000 | 32'(i),
                            {5'(i), 3'(i % 7 + 1)}, 8'(i)));
    send_frame(make_frame(1'b1, 8'd16, 32'h0, 32'h0, 8'h01, 8'h34));
    send_frame(make_frame(1'b1, 8'hFF, '1, '1, 8'h01, 8'h77));
    settle();
    set_register(CFG_RELAY_MARKER, 8'hFF);

    send_gap_pct = 9;
    recv_stall_pct = 79;
    send_random(130);
    settle();
    set_register(CFG_SPARE_A, 8'($urandom));
    set_register(CFG_SPARE_B, 8'($urandom));
    set_register(CFG_RELAY_ENABLE, 8'hFE);

    send_gap_pct = 79;
    recv_stall_pct = 9;
    send_random(50);
    settle();
    set_register(CFG_RELAY_ENABLE, 8'h03);
    set_register(CFG_RELAY_MARKER, 8'($urandom));
    send_random(80);
    settle();
    set_register(CFG_RELAY_MARKER, 8'($urandom));

    send_gap_pct = 0;
    recv_stall_pct = 0;
    hold_cycles = 300;
    send_random(140);
    settle();
    repeat (40) @(posedge clk);
    if (sb.pending_reports.size() != 0) sb.flag("expected results left over at the end");

    if (sb.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule

@@ sim.f @@
hdl/frdf_pkg.sv
hdl/frdf_ifs.sv
hdl/frdf_ram.sv
hdl/flood_relay_dedup_filter.sv
bench/testbench.sv
